// File: design/fvn_pkg.sv
// Shared types, constants and stage indexes for the fractal value noise generator.
`default_nettype none

package fvn_pkg;

    // Pipeline stage indexes
    localparam int ST_IN   = 0;   // position capture
    localparam int ST_U    = 1;   // hash: shift-xor
    localparam int ST_SQ   = 2;   // hash: u*u
    localparam int ST_MUL1 = 3;   // hash: *15731 + 789221
    localparam int ST_MUL2 = 4;   // hash: u*t + 1376312589, mask
    localparam int ST_DIV  = 5;   // hash: /0xffff - 0x7fff
    localparam int ST_DIFF = 6;   // blend: h1 - h0
    localparam int ST_PROD = 7;   // blend: diff * frac
    localparam int ST_TERM = 8;   // blend: add, shift
    localparam int ST_PSUM = 9;   // partial sums
    localparam int ST_OUT  = 10;  // output register
    localparam int NUM_ST  = 11;

    localparam int NUM_OCT = 9;
    localparam int OCT_TOP = 8;
    localparam int FRAC_W  = 8;

    localparam logic [31:0] HASH_MUL  = 32'd15731;
    localparam logic [31:0] HASH_ADD1 = 32'd789221;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
    localparam logic signed [16:0] HASH_BIAS = 17'sd32767;

    localparam logic [3:0] LIMIT_RESET = 4'd6;

    typedef logic [NUM_ST-1:0]  t_stg_vec;
    typedef logic signed [16:0] t_hash;
    typedef logic signed [15:0] t_term;

endpackage

`default_nettype wire

// File: design/fvn_hash.sv
// Five-stage integer lattice hash, result in -32767..1.
`default_nettype none

module fvn_hash (
    input  wire logic             i_clk,
    input  wire fvn_pkg::t_stg_vec i_en,
    input  wire logic [31:0]      i_point,
    output fvn_pkg::t_hash        o_hash
);

    logic [31:0] r_u1;
    logic [31:0] r_u2;
    logic [31:0] r_sq2;
    logic [31:0] r_u3;
    logic [31:0] r_t3;
    logic [30:0] r_t4;
    fvn_pkg::t_hash r_h5;

    logic [31:0] n_u1;
    logic [31:0] n_sq2;
    logic [31:0] n_t3;
    logic [31:0] n_t4;
    logic [31:0] q_sum;
    logic [15:0] quo;
    fvn_pkg::t_hash n_h5;

    always_comb begin
        n_u1  = (i_point << 13) ^ i_point;
        n_sq2 = r_u1 * r_u1;
        n_t3  = r_sq2 * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD1;
        n_t4  = r_u3 * r_t3 + fvn_pkg::HASH_ADD2;
        // t / 0xffff for t < 2^31: (t + (t >> 16) + 1) >> 16
        q_sum = {1'b0, r_t4} + {17'd0, r_t4[30:16]} + 32'd1;
        quo   = q_sum[31:16];
        n_h5  = $signed({1'b0, quo}) - fvn_pkg::HASH_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[fvn_pkg::ST_U]) begin
            r_u1 <= n_u1;
        end
        if (i_en[fvn_pkg::ST_SQ]) begin
            r_u2  <= r_u1;
            r_sq2 <= n_sq2;
        end
        if (i_en[fvn_pkg::ST_MUL1]) begin
            r_u3 <= r_u2;
            r_t3 <= n_t3;
        end
        if (i_en[fvn_pkg::ST_MUL2]) begin
            r_t4 <= n_t4[30:0];
        end
        if (i_en[fvn_pkg::ST_DIV]) begin
            r_h5 <= n_h5;
        end
    end

    assign o_hash = r_h5;

endmodule

`default_nettype wire

// File: design/fvn_octave.sv
// One octave lane: two lattice hashes and the linear blend, giving the shifted term.
`default_nettype none

module fvn_octave (
    input  wire logic                        i_clk,
    input  wire fvn_pkg::t_stg_vec            i_en,
    input  wire logic [31:0]                 i_cell,
    input  wire logic [fvn_pkg::FRAC_W-1:0]  i_frac,
    input  wire logic [3:0]                  i_shift,
    output fvn_pkg::t_term                   o_term
);

    fvn_pkg::t_hash h0;
    fvn_pkg::t_hash h1;
    logic [31:0] cell_next;

    // frac delay line, stages ST_U..ST_DIFF
    logic [fvn_pkg::FRAC_W-1:0] r_frac [fvn_pkg::ST_U:fvn_pkg::ST_DIFF];

    logic signed [17:0] r_diff;
    fvn_pkg::t_hash     r_h0_6;
    fvn_pkg::t_hash     r_h0_7;
    logic signed [24:0] r_prod;
    fvn_pkg::t_term     r_term;

    logic signed [17:0] n_diff;
    logic signed [26:0] prod_full;
    logic signed [25:0] base;
    logic signed [25:0] acc;

    assign cell_next = i_cell + 32'd1;  // wraps to 0 at the last lattice point

    fvn_hash u_hash_lo (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_point (i_cell),
        .o_hash  (h0)
    );

    fvn_hash u_hash_hi (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_point (cell_next),
        .o_hash  (h1)
    );

    always_comb begin
        n_diff    = 18'(h1) - 18'(h0);
        prod_full = r_diff * $signed({1'b0, r_frac[fvn_pkg::ST_DIFF]});
        // h0 * 2^k + (h1 - h0) * frac == h1*frac + h0*(2^k - frac)
        base      = 26'(r_h0_7) <<< i_shift;
        acc       = base + 26'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[fvn_pkg::ST_U]) begin
            r_frac[fvn_pkg::ST_U] <= i_frac;
        end
        for (int s = fvn_pkg::ST_U + 1; s <= fvn_pkg::ST_DIFF; s++) begin
            if (i_en[s]) begin
                r_frac[s] <= r_frac[s-1];
            end
        end
        if (i_en[fvn_pkg::ST_DIFF]) begin
            r_diff <= n_diff;
            r_h0_6 <= h0;
        end
        if (i_en[fvn_pkg::ST_PROD]) begin
            r_prod <= prod_full[24:0];
            r_h0_7 <= r_h0_6;
        end
        if (i_en[fvn_pkg::ST_TERM]) begin
            // floor by 2^k then by 2^(i+1) is floor by 2^9 for every octave
            r_term <= acc[24:9];
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

// File: design/fractal_value_noise_generator_core.sv
// Fractal value noise generator top level: input stage, octave lanes, summing tree.
// Path: an accepted item passes through every stage, ST_IN to ST_OUT, to reach the output.
// Throughput: one item per cycle when not stalled; eleven register stages, set by the three
//   32-bit multiplies of the lattice hash and the blend multiply, each with its own stage.
// Stalls: each stage loads when it is empty or the stage after it moves, so bubbles
//   close up and the input keeps flowing while a result waits, until every stage is full.
// Reset (synchronous, active low): clears all stage valid bits; octave_limit goes to 6.
`default_nettype none

module fractal_value_noise_generator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_position,
    // result item channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [15:0] o_sample,
    // octave_limit register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_octave_limit
);

    fvn_pkg::t_stg_vec r_vld;
    fvn_pkg::t_stg_vec stg_en;

    logic [3:0]  r_octave_limit;
    logic [31:0] r_x;

    fvn_pkg::t_term terms  [fvn_pkg::NUM_OCT];
    fvn_pkg::t_term masked [fvn_pkg::NUM_OCT];
    fvn_pkg::t_term r_psum [3];
    fvn_pkg::t_term n_psum [3];
    fvn_pkg::t_term r_sample;

    // Stage load enables: a stage takes new contents when it is empty or
    // when its own contents move on this cycle.
    always_comb begin
        stg_en[fvn_pkg::ST_OUT] = !r_vld[fvn_pkg::ST_OUT] || !i_out_stall;
        for (int s = fvn_pkg::NUM_ST - 2; s >= 0; s--) begin
            stg_en[s] = !r_vld[s] || stg_en[s+1];
        end
    end

    assign o_in_stall  = !stg_en[fvn_pkg::ST_IN];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '0;
            r_octave_limit <= fvn_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_octave_limit <= i_cfg_octave_limit;
            end
            if (stg_en[fvn_pkg::ST_IN]) begin
                r_vld[fvn_pkg::ST_IN] <= i_in_valid;
            end
            for (int s = 1; s < fvn_pkg::NUM_ST; s++) begin
                if (stg_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (stg_en[fvn_pkg::ST_IN]) begin
            r_x <= i_position;
        end
    end

    // One lane per octave; octave i works on k = 8 - i fraction bits.
    for (genvar i = 0; i < fvn_pkg::NUM_OCT; i++) begin : g_oct
        localparam int K = fvn_pkg::OCT_TOP - i;

        logic [31:0]                lat_pt;
        logic [31:0]                frac_w;
        logic [fvn_pkg::FRAC_W-1:0] frac;

        assign lat_pt = r_x >> K;
        assign frac_w = r_x & ((32'd1 << K) - 32'd1);
        assign frac   = frac_w[fvn_pkg::FRAC_W-1:0];

        fvn_octave u_octave (
            .i_clk   (i_clk),
            .i_en    (stg_en),
            .i_cell  (lat_pt),
            .i_frac  (frac),
            .i_shift (4'(K)),
            .o_term  (terms[i])
        );

        // octaves above the limit contribute nothing; limits 9..15 act as 8
        assign masked[i] = (4'(i) <= r_octave_limit) ? terms[i] : '0;
    end

    // Summing tree: three groups of three, then the final 16-bit wrapping sum.
    always_comb begin
        for (int g = 0; g < 3; g++) begin
            n_psum[g] = masked[3*g] + masked[3*g+1] + masked[3*g+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[fvn_pkg::ST_PSUM]) begin
            for (int g = 0; g < 3; g++) begin
                r_psum[g] <= n_psum[g];
            end
        end
        if (stg_en[fvn_pkg::ST_OUT]) begin
            r_sample <= r_psum[0] + r_psum[1] + r_psum[2];
        end
    end

    assign o_out_valid = r_vld[fvn_pkg::ST_OUT];
    assign o_sample    = r_sample;

endmodule

`default_nettype wire

// File: verif/tb_fractal_value_noise_generator_core.sv
// Self-checking testbench for the fractal value noise generator core.
`timescale 1ns / 1ps

module tb_fractal_value_noise_generator_core;

    // Clock, reset and the block's ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [31:0]        i_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_sample;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_octave_limit = '0;

    localparam int OCTAVE_MAX     = 8;
    localparam int DRAIN_CYCLES   = 20;    // quiet wait after the last owed sample, with margin over the pipeline depth
    localparam int WATCHDOG_LIMIT = 2000;  // cycles in a row with no handshake at all
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 200;

    // Directed stimulus: an item on the input channel or a new octave limit.
    typedef enum logic {ROW_ITEM, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;     // position, or octave limit in the low nibble
        logic        has_exp;   // expected sample typed in below
        logic [15:0] exp;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 23;

    // Rows without a typed sample go through the predictor.
    // Position 0 with only octave 0: lattice point 0 hashes to -11766 and frac is 0,
    // so the sample is -11766 >>> 1 = -5883 (0xE905).
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_ITEM,  32'h0000_0000, 1'b0, 16'h0000},   // octave limit still at reset value
        '{ROW_ITEM,  32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'h8000_0000, 1'b0, 16'h0000},
        '{ROW_LIMIT, 32'd0,         1'b0, 16'h0000},   // single octave
        '{ROW_ITEM,  32'h0000_0000, 1'b1, 16'hE905},
        '{ROW_ITEM,  32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'h0000_00FF, 1'b0, 16'h0000},   // largest fraction of the coarse cell
        '{ROW_ITEM,  32'h0000_0100, 1'b0, 16'h0000},
        '{ROW_LIMIT, 32'd8,         1'b0, 16'h0000},   // all nine octaves
        '{ROW_ITEM,  32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'hFFFF_FFFF, 1'b0, 16'h0000},   // finest lattice point wraps to 0
        '{ROW_ITEM,  32'hFFFF_FF00, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'h7FFF_FFFF, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'h5555_5555, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'hAAAA_AAAA, 1'b0, 16'h0000},
        '{ROW_LIMIT, 32'd15,        1'b0, 16'h0000},   // above eight: saturates to eight
        '{ROW_ITEM,  32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'h1234_5678, 1'b0, 16'h0000},
        '{ROW_LIMIT, 32'd9,         1'b0, 16'h0000},
        '{ROW_ITEM,  32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_ITEM,  32'hFFFF_FFFE, 1'b0, 16'h0000},
        '{ROW_LIMIT, 32'd6,         1'b0, 16'h0000},
        '{ROW_ITEM,  32'h0F0F_0F0F, 1'b0, 16'h0000}
    };

    // Testbench copy of the octave limit register and the samples still owed.
    logic [3:0]  octave_limit_q = 4'd6;
    logic [15:0] pending_samples[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;

    fractal_value_noise_generator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_position         (i_position),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_sample           (o_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_octave_limit (i_cfg_octave_limit)
    );

    always #5 i_clk = ~i_clk;

    // Integer lattice hash in 32-bit wrapping arithmetic; lands in -32767..1.
    function automatic int cell_hash(logic [31:0] p);
        logic [31:0] u;
        logic [31:0] t;
        u = (p << 13) ^ p;
        t = u * u;
        t = t * 32'd15731;
        t = t + 32'd789221;
        t = u * t;
        t = t + 32'd1376312589;
        t = t & 32'h7FFF_FFFF;
        return int'(t / 32'hFFFF) - 32767;
    endfunction

    // Linear blend of the two neighboring lattice hashes over the low k bits,
    // rounded toward minus infinity.
    function automatic int octave_blend(logic [31:0] x, int k);
        logic [31:0] lat_pt;
        int          frac;
        int          h0;
        int          h1;
        lat_pt = x >> k;
        frac   = int'(x & ((32'd1 << k) - 32'd1));
        h0     = cell_hash(lat_pt);
        h1     = cell_hash(lat_pt + 32'd1);
        return (h1 * frac + h0 * ((1 << k) - frac)) >>> k;
    endfunction

    // Octaves 0..limit, each halved once more than the one before, into a 16-bit sum.
    function automatic logic [15:0] noise_sample(logic [31:0] x, logic [3:0] limit);
        int          last;
        int          term;
        logic [15:0] sum;
        last = (limit > OCTAVE_MAX) ? OCTAVE_MAX : int'(limit);
        sum  = '0;
        for (int i = 0; i <= last; i++) begin
            term = octave_blend(x, OCTAVE_MAX - i) >>> (i + 1);
            sum  = sum + term[15:0];
        end
        return sum;
    endfunction

    // Random positions: mostly full range, some pinned near either end.
    function automatic logic [31:0] pick_position();
        case ($urandom_range(9))
            0:       return {24'hFF_FFFF, 8'($urandom)};
            1:       return {24'h00_0000, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Present one item with random leading gaps; hold it until the block takes it.
    // Called and returning at a falling edge; valid stays high for the next item.
    task automatic send_item(logic [31:0] pos, logic has_exp, logic [15:0] exp);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        pending_samples.push_back(has_exp ? exp : noise_sample(pos, octave_limit_q));
        @(negedge i_clk);
    endtask

    // Register write only once the pipeline has emptied and settled.
    task automatic set_octave_limit(logic [3:0] limit);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_octave_limit <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid    <= 1'b0;
        octave_limit_q  = limit;
    endtask

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Result checker and no-progress watchdog; outputs sampled at the rising edge.
    // A sample that nothing was owed for does not count as progress.
    always @(posedge i_clk) begin
        logic [15:0] want;
        if ((i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall && pending_samples.size() != 0) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %0d",
                         $time, o_sample);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, $signed(want), o_sample);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial begin
        logic [3:0] seg_limit;
        // Synchronous reset, released away from the clock edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the first idling profile.
        in_idle_pct   = 11;
        out_stall_pct = 47;
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_LIMIT) begin
                set_octave_limit(DIRECTED[r].value[3:0]);
            end else begin
                send_item(DIRECTED[r].value, DIRECTED[r].has_exp, DIRECTED[r].exp);
            end
        end

        // Random part: segments with a new octave limit each, the extremes first.
        // Idling: sender light / receiver heavy, then swapped, then none at all.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       seg_limit = 4'd0;
                1:       seg_limit = 4'd8;
                2:       seg_limit = 4'd15;
                default: seg_limit = 4'($urandom_range(15));
            endcase
            set_octave_limit(seg_limit);
            if (seg < 3) begin
                in_idle_pct   = 11;
                out_stall_pct = 47;
            end else if (seg < 6) begin
                in_idle_pct   = 47;
                out_stall_pct = 11;
            end else begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                send_item(pick_position(), 1'b0, 16'h0000);
            end
        end

        // Drain: every owed sample must show up, then a quiet tail.
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/fvn_pkg.sv
design/fvn_hash.sv
design/fvn_octave.sv
design/fractal_value_noise_generator_core.sv
verif/tb_fractal_value_noise_generator_core.sv
